// ----- rtl/lavm_pkg.sv -----
// Package for the look-at view matrix pipeline.
// Holds the fixed-point widths and stage counts used by the scale, unit and top modules.
// No dependencies.
package lavm_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int NORM_BITS      = 30;
    localparam int AXIS_BITS      = 32;
    localparam int SQ_BITS        = 2 * NORM_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int Q_BITS         = NORM_BITS + 1;
    localparam int REM_BITS       = Q_BITS + 2;
    localparam int PROD_BITS      = 64;
    localparam int SCALE_LAT      = 2;
    localparam int SQRT_LAT       = 31;
    localparam int DIV_LAT        = 31;
    localparam int UNIT_LAT       = SCALE_LAT + 2 + SQRT_LAT + DIV_LAT;

    typedef logic signed [AXIS_BITS-1:0] axis_t;

endpackage

// ----- rtl/look_at_view_matrix_top.sv -----
// Top level of the look-at view matrix pipeline.
// Depends on lavm_pkg, lavm_delay, lavm_scale and lavm_unit.
//
// Channel   Direction  Contents
// s_axis    in         eye x/y/z, target x/y/z, up x/y/z
// m_axis    out        right, true up, forward axes, shift x/y/z
//
// One camera is taken every cycle while the output register is not stalled;
// its result is presented on m_axis after passing through the two unit-vector
// pipelines, each with a 31-stage square root and a 31-stage divider.
// Reset clears all valid bits. When the output register holds a transfer
// that is not taken, every stage holds, and s_axis_tready is low.
module look_at_view_matrix_top #(
    parameter int COORD_BITS = lavm_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // right_x/y/z, true_up_x/y/z, forward_x/y/z, shift_x, shift_y, shift_z
    output logic [((9*lavm_pkg::AXIS_BITS+3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import lavm_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int OUT_DW = 9 * AXIS_BITS + 3 * CB;
    localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;
    localparam int D_W    = CB + 1;
    localparam int UP_W   = NORM_BITS + 1;
    localparam int LO     = CB / 2;
    localparam int HI_W   = CB - LO;
    localparam int PH_W   = AXIS_BITS + HI_W;
    localparam int PL_W   = AXIS_BITS + LO + 1;
    localparam int HS_W   = PH_W + 2;
    localparam int LS_W   = PL_W + 2;
    localparam int TOT_W  = HS_W + LO + 1;
    localparam int F_W    = TOT_W - NORM_BITS;
    localparam int R_W    = F_W + 1;

    localparam int P_IN  = 1;
    localparam int P_D   = P_IN + 1;
    localparam int P_UPN = P_IN + SCALE_LAT;
    localparam int P_FWD = P_D + UNIT_LAT;
    localparam int P_RC  = P_FWD + 2;
    localparam int P_RGT = P_RC + UNIT_LAT;
    localparam int P_TUP = P_RGT + 2;
    localparam int P_NEG = P_TUP + 4;

    localparam logic signed [PROD_BITS-1:0] HALF_P = PROD_BITS'(1) << (NORM_BITS - 1);
    localparam logic signed [PROD_BITS-1:0] ONE_P  = PROD_BITS'(1) << NORM_BITS;
    localparam logic signed [TOT_W-1:0]     HALF_T = TOT_W'(1) << (NORM_BITS - 1);
    localparam logic signed [R_W-1:0] SAT_MAX = {{(R_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [R_W-1:0] SAT_MIN = {{(R_W-CB+1){1'b1}}, {(CB-1){1'b0}}};

    logic                   adv;
    logic                   in_valid_reg;
    logic signed [CB-1:0]   eye_reg [3];
    logic signed [CB-1:0]   tgt_reg [3];
    logic signed [CB-1:0]   up_reg [3];
    logic signed [D_W-1:0]  d_reg [3];
    axis_t                  fwd [3];
    logic [NORM_BITS-1:0]   upm [3];
    logic [2:0]             upneg;
    logic [3*UP_W-1:0]      upn_pk;
    logic [3*UP_W-1:0]      upn_dly_pk;
    logic signed [UP_W-1:0] upn [3];
    logic signed [PROD_BITS-1:0] xa_reg [6];
    logic signed [PROD_BITS-1:0] rc_reg [3];
    axis_t                  rgt [3];
    logic [3*AXIS_BITS-1:0] fwd_pk;
    logic [3*AXIS_BITS-1:0] fwd_dly_pk;
    axis_t                  fwd_r [3];
    logic signed [PROD_BITS-1:0] tb_reg [6];
    axis_t                  tup_next [3];
    axis_t                  tup_reg [3];
    logic [6*AXIS_BITS-1:0] rf_pk;
    logic [6*AXIS_BITS-1:0] rf_dly_pk;
    axis_t                  ax [3][3];
    logic [3*CB-1:0]        eye_pk;
    logic [3*CB-1:0]        eye_dly_pk;
    logic signed [CB-1:0]   eye_t [3];
    logic signed [PH_W-1:0] ph_reg [3][3];
    logic signed [PL_W-1:0] pl_reg [3][3];
    logic signed [HS_W-1:0] hs_reg [3];
    logic signed [LS_W-1:0] ls_reg [3];
    logic signed [F_W-1:0]  f_reg [3];
    logic signed [CB-1:0]   shift_reg [3];
    logic [9*AXIS_BITS-1:0] ax_pk;
    logic [9*AXIS_BITS-1:0] ax_dly_pk;
    logic                   valid_neg;
    logic                   out_valid_reg;
    logic [OUT_TW-1:0]      out_data_reg;
    logic [OUT_TW-1:0]      out_data_next;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= s_axis_tvalid;
            out_valid_reg <= valid_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= s_axis_tdata[i*CB +: CB];
                tgt_reg[i] <= s_axis_tdata[(3+i)*CB +: CB];
                up_reg[i]  <= s_axis_tdata[(6+i)*CB +: CB];
                d_reg[i]   <= D_W'(tgt_reg[i]) - D_W'(eye_reg[i]);
            end
        end
    end

    lavm_unit #(.IN_W(D_W)) u_fwd (
        .clk    (clk),
        .en     (adv),
        .vec    (d_reg),
        .unit_o (fwd)
    );

    lavm_scale #(.IN_W(CB)) u_up (
        .clk (clk),
        .en  (adv),
        .vec (up_reg),
        .mag (upm),
        .neg (upneg)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            upn_pk[i*UP_W +: UP_W] = upneg[i] ? UP_W'(0) - UP_W'(upm[i]) : UP_W'(upm[i]);
            upn[i]                 = $signed(upn_dly_pk[i*UP_W +: UP_W]);
            fwd_pk[i*AXIS_BITS +: AXIS_BITS] = fwd[i];
            fwd_r[i] = $signed(fwd_dly_pk[i*AXIS_BITS +: AXIS_BITS]);
            rf_pk[i*AXIS_BITS +: AXIS_BITS]     = rgt[i];
            rf_pk[(3+i)*AXIS_BITS +: AXIS_BITS] = fwd_r[i];
            eye_pk[i*CB +: CB] = eye_reg[i];
            eye_t[i]           = $signed(eye_dly_pk[i*CB +: CB]);
            ax[0][i] = $signed(rf_dly_pk[i*AXIS_BITS +: AXIS_BITS]);
            ax[1][i] = tup_reg[i];
            ax[2][i] = $signed(rf_dly_pk[(3+i)*AXIS_BITS +: AXIS_BITS]);
        end
    end

    lavm_delay #(.WIDTH(3*UP_W), .DEPTH(P_FWD-P_UPN)) u_upn_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (upn_pk), .q (upn_dly_pk)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xa_reg[0] <= PROD_BITS'(upn[1]) * PROD_BITS'(fwd[2]);
            xa_reg[1] <= PROD_BITS'(upn[2]) * PROD_BITS'(fwd[1]);
            xa_reg[2] <= PROD_BITS'(upn[2]) * PROD_BITS'(fwd[0]);
            xa_reg[3] <= PROD_BITS'(upn[0]) * PROD_BITS'(fwd[2]);
            xa_reg[4] <= PROD_BITS'(upn[0]) * PROD_BITS'(fwd[1]);
            xa_reg[5] <= PROD_BITS'(upn[1]) * PROD_BITS'(fwd[0]);
            for (int i = 0; i < 3; i++)
            begin
                rc_reg[i] <= xa_reg[2*i] - xa_reg[2*i+1];
            end
        end
    end

    lavm_unit #(.IN_W(PROD_BITS)) u_rgt (
        .clk    (clk),
        .en     (adv),
        .vec    (rc_reg),
        .unit_o (rgt)
    );

    lavm_delay #(.WIDTH(3*AXIS_BITS), .DEPTH(P_RGT-P_FWD)) u_fwd_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (fwd_pk), .q (fwd_dly_pk)
    );

    always_comb
    begin
        logic signed [PROD_BITS-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t = (tb_reg[2*i] - tb_reg[2*i+1] + HALF_P) >>> NORM_BITS;
            if (t > ONE_P)
            begin
                tup_next[i] = AXIS_BITS'(ONE_P);
            end
            else if (t < -ONE_P)
            begin
                tup_next[i] = AXIS_BITS'(-ONE_P);
            end
            else
            begin
                tup_next[i] = AXIS_BITS'(t);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tb_reg[0] <= PROD_BITS'(fwd_r[1]) * PROD_BITS'(rgt[2]);
            tb_reg[1] <= PROD_BITS'(fwd_r[2]) * PROD_BITS'(rgt[1]);
            tb_reg[2] <= PROD_BITS'(fwd_r[2]) * PROD_BITS'(rgt[0]);
            tb_reg[3] <= PROD_BITS'(fwd_r[0]) * PROD_BITS'(rgt[2]);
            tb_reg[4] <= PROD_BITS'(fwd_r[0]) * PROD_BITS'(rgt[1]);
            tb_reg[5] <= PROD_BITS'(fwd_r[1]) * PROD_BITS'(rgt[0]);
            tup_reg   <= tup_next;
        end
    end

    lavm_delay #(.WIDTH(6*AXIS_BITS), .DEPTH(P_TUP-P_RGT)) u_rf_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (rf_pk), .q (rf_dly_pk)
    );

    lavm_delay #(.WIDTH(3*CB), .DEPTH(P_TUP-P_IN)) u_eye_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (eye_pk), .q (eye_dly_pk)
    );

    always_ff @(posedge clk)
    begin
        logic signed [TOT_W-1:0] tot;
        logic signed [R_W-1:0]   r;
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ph_reg[k][i] <= PH_W'(ax[k][i]) * PH_W'($signed(eye_t[i][CB-1:LO]));
                    pl_reg[k][i] <= PL_W'(ax[k][i])
                                    * PL_W'($signed({1'b0, eye_t[i][LO-1:0]}));
                end
                hs_reg[k] <= HS_W'(ph_reg[k][0]) + HS_W'(ph_reg[k][1])
                             + HS_W'(ph_reg[k][2]);
                ls_reg[k] <= LS_W'(pl_reg[k][0]) + LS_W'(pl_reg[k][1])
                             + LS_W'(pl_reg[k][2]);
                tot = (TOT_W'(hs_reg[k]) <<< LO) + TOT_W'(ls_reg[k]) + HALF_T;
                f_reg[k] <= F_W'(tot >>> NORM_BITS);
                r = -R_W'(f_reg[k]);
                if (r > SAT_MAX)
                begin
                    shift_reg[k] <= CB'(SAT_MAX);
                end
                else if (r < SAT_MIN)
                begin
                    shift_reg[k] <= CB'(SAT_MIN);
                end
                else
                begin
                    shift_reg[k] <= CB'(r);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ax_pk[(3*k+i)*AXIS_BITS +: AXIS_BITS] =
                    (k == 0) ? rf_dly_pk[i*AXIS_BITS +: AXIS_BITS]
                    : (k == 1) ? tup_reg[i] : rf_dly_pk[(3+i)*AXIS_BITS +: AXIS_BITS];
            end
        end
        out_data_next = '0;
        out_data_next[9*AXIS_BITS-1:0] = ax_dly_pk;
        for (int k = 0; k < 3; k++)
        begin
            out_data_next[9*AXIS_BITS + k*CB +: CB] = shift_reg[k];
        end
    end

    lavm_delay #(.WIDTH(9*AXIS_BITS), .DEPTH(P_NEG-P_TUP)) u_ax_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (ax_pk), .q (ax_dly_pk)
    );

    lavm_delay #(.WIDTH(1), .DEPTH(P_NEG-P_IN)) u_valid_dly (
        .clk (clk), .rst_n (rst_n), .en (adv), .d (in_valid_reg), .q (valid_neg)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end
endmodule

// ----- rtl/lavm_delay.sv -----
// Enabled shift line that delays a word by DEPTH stages.
// Depends on nothing.
module lavm_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];
endmodule

// ----- rtl/lavm_scale.sv -----
// Block scaler: brings the largest magnitude of a 3-vector to bit 29.
// Two stages, leading-one search then shift. Depends on lavm_pkg.
module lavm_scale #(
    parameter int IN_W = 33
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [IN_W-1:0]               vec [3],
    output logic [lavm_pkg::NORM_BITS-1:0]       mag [3],
    output logic [2:0]                           neg
);
    import lavm_pkg::*;

    localparam int PW  = $clog2(IN_W);
    localparam int TOP = NORM_BITS - 1;
    localparam int WW  = IN_W + NORM_BITS;

    logic [IN_W-1:0]      mag_next [3];
    logic [IN_W-1:0]      mag_reg [3];
    logic [2:0]           neg_next;
    logic [2:0]           neg_reg;
    logic [2:0]           neg_out_reg;
    logic [PW-1:0]        pos_next;
    logic [PW-1:0]        pos_reg;
    logic [IN_W-1:0]      all_bits;
    logic [NORM_BITS-1:0] out_next [3];
    logic [NORM_BITS-1:0] out_reg [3];

    always_comb
    begin
        all_bits = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = vec[i][IN_W-1];
            mag_next[i] = vec[i][IN_W-1] ? IN_W'(-vec[i]) : IN_W'(vec[i]);
            all_bits    = all_bits | mag_next[i];
        end
        pos_next = '0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (all_bits[b])
            begin
                pos_next = PW'(b);
            end
        end
    end

    always_comb
    begin
        logic [WW-1:0] wide;
        for (int i = 0; i < 3; i++)
        begin
            wide = WW'(mag_reg[i]);
            if (int'(pos_reg) >= TOP)
            begin
                wide = wide >> (int'(pos_reg) - TOP);
            end
            else
            begin
                wide = wide << (TOP - int'(pos_reg));
            end
            out_next[i] = wide[NORM_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            pos_reg     <= pos_next;
            out_reg     <= out_next;
            neg_out_reg <= neg_reg;
        end
    end

    assign mag = out_reg;
    assign neg = neg_out_reg;
endmodule

// ----- rtl/lavm_unit.sv -----
// Unit-vector pipeline: block scale, sum of squares, bit-per-stage square
// root and bit-per-stage division. Depends on lavm_pkg and lavm_scale.
module lavm_unit #(
    parameter int IN_W = 33
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] vec [3],
    output lavm_pkg::axis_t        unit_o [3]
);
    import lavm_pkg::*;

    logic [NORM_BITS-1:0] mag_s [3];
    logic [2:0]           neg_s;

    logic [SQ_BITS-1:0]   sq_reg [3];
    logic [NORM_BITS-1:0] mag_a_reg [3];
    logic [2:0]           neg_a_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [NORM_BITS-1:0] mag_b_reg [3];
    logic [2:0]           neg_b_reg;

    logic [SUM_BITS-1:0]  rs_reg [SQRT_LAT];
    logic [SUM_BITS-1:0]  rr_reg [SQRT_LAT];
    logic [SUM_BITS-1:0]  rs_next [SQRT_LAT];
    logic [SUM_BITS-1:0]  rr_next [SQRT_LAT];
    logic [NORM_BITS-1:0] mag_q_reg [SQRT_LAT][3];
    logic [2:0]           neg_q_reg [SQRT_LAT];

    logic [REM_BITS-1:0]  rem_reg [DIV_LAT][3];
    logic [REM_BITS-1:0]  rem_next [DIV_LAT][3];
    logic [Q_BITS-1:0]    q_reg [DIV_LAT][3];
    logic [Q_BITS-1:0]    q_next [DIV_LAT][3];
    logic [Q_BITS-1:0]    den_reg [DIV_LAT];
    logic [Q_BITS-1:0]    den_next [DIV_LAT];
    logic [2:0]           neg_d_reg [DIV_LAT];
    logic [2:0]           neg_d_next [DIV_LAT];
    logic                 zero_reg [DIV_LAT];
    logic                 zero_next [DIV_LAT];

    lavm_scale #(.IN_W(IN_W)) u_scale (
        .clk (clk),
        .en  (en),
        .vec (vec),
        .mag (mag_s),
        .neg (neg_s)
    );

    always_comb
    begin
        logic [SUM_BITS-1:0] s_in;
        logic [SUM_BITS-1:0] r_in;
        logic [SUM_BITS-1:0] bitv;
        logic [SUM_BITS-1:0] t;
        for (int j = 0; j < SQRT_LAT; j++)
        begin
            if (j == 0)
            begin
                s_in = sum_reg;
                r_in = '0;
            end
            else
            begin
                s_in = rs_reg[j-1];
                r_in = rr_reg[j-1];
            end
            bitv = SUM_BITS'(1) << (2 * (SQRT_LAT - 1 - j));
            t    = r_in + bitv;
            if (s_in >= t)
            begin
                rs_next[j] = s_in - t;
                rr_next[j] = (r_in >> 1) + bitv;
            end
            else
            begin
                rs_next[j] = s_in;
                rr_next[j] = r_in >> 1;
            end
        end
    end

    always_comb
    begin
        logic [REM_BITS-1:0] rem_in;
        logic [REM_BITS-1:0] diff;
        logic [Q_BITS-1:0]   q_in;
        logic [Q_BITS-1:0]   den_in;
        logic                ge;
        for (int j = 0; j < DIV_LAT; j++)
        begin
            if (j == 0)
            begin
                den_in        = rr_reg[SQRT_LAT-1][Q_BITS-1:0];
                neg_d_next[j] = neg_q_reg[SQRT_LAT-1];
                zero_next[j]  = (rr_reg[SQRT_LAT-1] == '0);
            end
            else
            begin
                den_in        = den_reg[j-1];
                neg_d_next[j] = neg_d_reg[j-1];
                zero_next[j]  = zero_reg[j-1];
            end
            den_next[j] = den_in;
            for (int i = 0; i < 3; i++)
            begin
                if (j == 0)
                begin
                    rem_in = REM_BITS'(mag_q_reg[SQRT_LAT-1][i]);
                    q_in   = '0;
                end
                else
                begin
                    rem_in = rem_reg[j-1][i];
                    q_in   = q_reg[j-1][i];
                end
                ge             = (rem_in >= REM_BITS'(den_in));
                diff           = ge ? rem_in - REM_BITS'(den_in) : rem_in;
                rem_next[j][i] = diff << 1;
                q_next[j][i]   = {q_in[Q_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= mag_s[i] * mag_s[i];
            end
            mag_a_reg <= mag_s;
            neg_a_reg <= neg_s;
            sum_reg   <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1])
                         + SUM_BITS'(sq_reg[2]);
            mag_b_reg <= mag_a_reg;
            neg_b_reg <= neg_a_reg;
            rs_reg    <= rs_next;
            rr_reg    <= rr_next;
            mag_q_reg[0] <= mag_b_reg;
            neg_q_reg[0] <= neg_b_reg;
            for (int j = 1; j < SQRT_LAT; j++)
            begin
                mag_q_reg[j] <= mag_q_reg[j-1];
                neg_q_reg[j] <= neg_q_reg[j-1];
            end
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            den_reg   <= den_next;
            neg_d_reg <= neg_d_next;
            zero_reg  <= zero_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg[DIV_LAT-1])
            begin
                unit_o[i] = '0;
            end
            else if (neg_d_reg[DIV_LAT-1][i])
            begin
                unit_o[i] = -$signed(AXIS_BITS'(q_reg[DIV_LAT-1][i]));
            end
            else
            begin
                unit_o[i] = $signed(AXIS_BITS'(q_reg[DIV_LAT-1][i]));
            end
        end
    end
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for look_at_view_matrix_top: directed and random cameras,
// a predictor of the fixed-point look-at matrix, and a scoreboard on m_axis.
// Depends on the look_at_view_matrix_top RTL, which itself uses lavm_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [8:0][31:0] camera_t;
    typedef logic [11:0][31:0] view_t;
    typedef longint vec3_t [3];

    localparam longint ONE30 = longint'(1) << 30;
    localparam longint HALF30 = longint'(1) << 29;
    localparam longint LIMIT_CYCLES = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [383:0] m_axis_tdata;

    camera_t pending_cams[$];
    view_t expected_views[$];
    int errors = 0;
    longint cycle = 0;
    int sent = 0;

    look_at_view_matrix_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned mag64(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = longint'(1) << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic vec3_t block_scale(vec3_t v);
        vec3_t o;
        longint unsigned m = 0;
        longint unsigned s;
        int k = 0;
        bit shr = 0;
        for (int i = 0; i < 3; i++)
            if (mag64(v[i]) > m)
                m = mag64(v[i]);
        if (m == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return o;
        end
        if (m >= ONE30)
        begin
            shr = 1;
            while ((m >> k) >= ONE30)
                k++;
        end
        else
        begin
            while ((m << k) < HALF30)
                k++;
        end
        for (int i = 0; i < 3; i++)
        begin
            s = shr ? (mag64(v[i]) >> k) : (mag64(v[i]) << k);
            o[i] = v[i] < 0 ? -longint'(s) : longint'(s);
        end
        return o;
    endfunction

    function automatic vec3_t normalize(vec3_t v);
        vec3_t s;
        vec3_t o;
        longint unsigned sum = 0;
        longint unsigned len;
        longint unsigned q;
        s = block_scale(v);
        for (int i = 0; i < 3; i++)
            sum += mag64(s[i]) * mag64(s[i]);
        if (sum == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return o;
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag64(s[i]) << 30) / len;
            o[i] = s[i] < 0 ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    function automatic longint camera_shift(vec3_t axis, vec3_t eye);
        longint hi = 0;
        longint lo = 0;
        longint eh, el, whole, frac, r;
        for (int i = 0; i < 3; i++)
        begin
            eh = eye[i] >>> 16;
            el = eye[i] - eh * 65536;
            hi += axis[i] * eh;
            lo += axis[i] * el;
        end
        whole = hi >>> 14;
        frac = (hi - whole * 16384) * 65536 + lo + HALF30;
        r = -(whole + (frac >>> 30));
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic view_t predict_view(camera_t c);
        vec3_t eye, tgt, up, d, fwd, upn, rgt, tup;
        view_t v;
        longint t;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(c[i]));
            tgt[i] = longint'($signed(c[3 + i]));
            up[i] = longint'($signed(c[6 + i]));
            d[i] = tgt[i] - eye[i];
        end
        fwd = normalize(d);
        upn = block_scale(up);
        rgt = normalize(cross3(upn, fwd));
        tup = cross3(fwd, rgt);
        for (int i = 0; i < 3; i++)
        begin
            t = (tup[i] + HALF30) >>> 30;
            if (t > ONE30)
                t = ONE30;
            if (t < -ONE30)
                t = -ONE30;
            tup[i] = t;
            v[i] = rgt[i][31:0];
            v[3 + i] = tup[i][31:0];
            v[6 + i] = fwd[i][31:0];
        end
        t = camera_shift(rgt, eye);
        v[9] = t[31:0];
        t = camera_shift(tup, eye);
        v[10] = t[31:0];
        t = camera_shift(fwd, eye);
        v[11] = t[31:0];
        return v;
    endfunction

    task automatic report_mismatch(int field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch field %0d: got %h expected %h at cycle %0d",
            field, got, want, cycle);
    endtask

    function automatic camera_t make_camera(longint ex, longint ey, longint ez,
        longint tx, longint ty, longint tz, longint ux, longint uy, longint uz);
        camera_t c;
        c[0] = ex[31:0]; c[1] = ey[31:0]; c[2] = ez[31:0];
        c[3] = tx[31:0]; c[4] = ty[31:0]; c[5] = tz[31:0];
        c[6] = ux[31:0]; c[7] = uy[31:0]; c[8] = uz[31:0];
        return c;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            2: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
            default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                : 32'h80000000 + $urandom_range(0, 3);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_views.push_back(predict_view(camera_t'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cams.size() > 0 &&
                    ((sent >= 400 && sent < 600) || $urandom_range(0, 99) >= 31))
                begin
                    s_axis_tdata <= pending_cams.pop_front();
                    s_axis_tvalid <= 1'b1;
                    sent++;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        view_t got;
        view_t want;
        cycle++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = view_t'(m_axis_tdata);
            if (expected_views.size() == 0)
            begin
                report_mismatch(-1, got[0], 32'h0);
            end
            else
            begin
                want = expected_views.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[i] !== want[i])
                        report_mismatch(i, got[i], want[i]);
            end
        end
        if (rst_n)
            m_axis_tready <= (cycle > 3000 && cycle < 4500) || $urandom_range(0, 99) >= 31;
        if (cycle > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        longint big = 64'sd2147483647;
        longint low = -64'sd2147483648;
        longint one = 65536;
        pending_cams.push_back(make_camera(0, 0, 0, 0, 0, one, 0, one, 0));
        pending_cams.push_back(make_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one,
            0, one, 0));
        pending_cams.push_back(make_camera(0, 0, 0, one, 0, 0, 0, 0, 0));
        pending_cams.push_back(make_camera(0, 0, 0, 0, one, 0, 0, 5 * one, 0));
        pending_cams.push_back(make_camera(0, 0, 0, 0, one, 0, 0, -one, 0));
        pending_cams.push_back(make_camera(low, low, low, big, big, big, big, big, big));
        pending_cams.push_back(make_camera(big, big, big, low, low, low, low, low, low));
        pending_cams.push_back(make_camera(low, low, low, low, big, low, big, 0, 0));
        pending_cams.push_back(make_camera(big, 0, 0, low, 0, 0, 0, one, 0));
        pending_cams.push_back(make_camera(low, 0, 0, big, 0, 0, 0, 0, low));
        pending_cams.push_back(make_camera(big, big, big, big, big, big, 1, 1, 1));
        pending_cams.push_back(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_cams.push_back(make_camera(0, 0, 0, 1, 1, 1, 1, 0, 0));
        pending_cams.push_back(make_camera(big, low, big, low, big, low, -1, -1, 1));
        pending_cams.push_back(make_camera(low, big, low, 0, 0, 0, low, big, low));
        pending_cams.push_back(make_camera(-one, -one, -one, one, one, one, 0, one, 0));
        pending_cams.push_back(make_camera(big, big, low, 0, 0, 0, 0, 0, big));
        pending_cams.push_back(make_camera(3, -7, 11, -5, 2, 9, big, low, 1));
        for (int n = 0; n < 900; n++)
            pending_cams.push_back(camera_t'({random_coord(), random_coord(), random_coord(),
                random_coord(), random_coord(), random_coord(), random_coord(),
                random_coord(), random_coord()}));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_cams.size() == 0 && !s_axis_tvalid);
        wait (expected_views.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_views.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
